// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("port check failed");

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("port check failed");

`endif

// File: sv/bhfa_pkg.sv
// ----------------------------------------------------------------------------
// bhfa_pkg
// Codes and the sequencer state type of the bitmap hole-fit allocator.
// ----------------------------------------------------------------------------
package bhfa_pkg;

  // Operation codes carried on the input channel.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Fit policy codes; the unused code behaves as first fit.
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  // Bytes held in one map word.
  localparam int unsigned WORD_BITS = 8;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_MARK_RD,
    S_MARK_WR,
    S_CLEAR,
    S_RESP
  } state_t;

endpackage

// File: sv/bitmap_hole_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_hole_fit_allocator_unit
// Byte-granular allocator over an occupancy bitmap held in an 8-bit-wide RAM.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  in_     | slave     | tuser: operation; tdata: region_base, region_size
//  out_    | master    | tdata: status, granted_base, free_bytes, fits_total
//  cfg_    | APB slave | fit_policy; cfg_paddr is not decoded
//
//  During an allocate scan one map word (8 bytes) is examined per cycle
//  through the RAM read port; each marked word is then read and rewritten.
//  Mark reads and rewrites each word touched; clear sweeps the map to zero.
//  After reset the RAM is swept to zero (MEM_BYTES/8 words, 512 at 4096)
//  before the first input transfer is taken. The result waits in its register
//  until out_tready; no new input is taken until it has been transferred.
//  MEM_BYTES must be a power of two; the block does not check it.
// ----------------------------------------------------------------------------
module bitmap_hole_fit_allocator_unit #(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] region_base, [24:12] region_size
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] status, [13:2] granted_base,
                                  // [26:14] free_bytes, [27] fits_total
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW    = $clog2(MEM_BYTES);
  localparam int DEPTH = MEM_BYTES / bhfa_pkg::WORD_BITS;
  localparam int WA    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int XW    = (AW + 2 > 14) ? AW + 2 : 14;

  // Map RAM and its registered read port.
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          mem_re, mem_we;
  logic [WA-1:0] mem_raddr, mem_waddr;
  logic [7:0]    mem_wdata;

  bhfa_pkg::state_t state_r, state_nxt;
  logic [1:0]    policy_r;
  logic [12:0]   size_r, size_nxt;
  logic [WA:0]   cnt_r, cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [WA-1:0] proc_idx_r, proc_idx_nxt;
  logic [CW-1:0] run_len_r, run_len_nxt;
  logic [AW-1:0] run_start_r, run_start_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] pick_base_r, pick_base_nxt;
  logic [CW-1:0] pick_len_r, pick_len_nxt;
  logic [XW-1:0] mark_cur_r, mark_cur_nxt;
  logic [XW-1:0] mark_end_r, mark_end_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [AW-1:0] grant_r, grant_nxt;

  // Scan step results.
  logic [CW-1:0] s_len, s_pl;
  logic [AW-1:0] s_st, s_pb, s_byte;
  logic          s_fnd;
  // Final-run evaluation.
  logic          e_take;
  // Mark step results.
  logic [7:0]    m_mask;
  logic [3:0]    m_new;
  logic [XW-1:0] m_byte, m_next;

  // Decide whether a hole of length len replaces the current pick.
  function automatic logic take_hole(input logic [CW-1:0] len, input logic fnd,
                                     input logic [CW-1:0] pl, input logic [1:0] pol,
                                     input logic [12:0] sz);
    logic fits;
    fits = (len != '0) && (XW'(len) >= XW'(sz));
    return fits && (!fnd || ((pol == bhfa_pkg::POLICY_BEST) && (len < pl)) ||
                   ((pol == bhfa_pkg::POLICY_WORST) && (len > pl)));
  endfunction

  // Configuration register write and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, policy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= bhfa_pkg::POLICY_FIRST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      policy_r <= cfg_pwdata[1:0];
    end
  end

  // Map RAM: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Walk the eight bytes of the word just read, tracking the open hole.
  always_comb begin
    s_len  = run_len_r;
    s_st   = run_start_r;
    s_fnd  = found_r;
    s_pb   = pick_base_r;
    s_pl   = pick_len_r;
    s_byte = '0;
    for (int i = 0; i < 8; i++) begin
      s_byte = {proc_idx_r, 3'(i)};
      if (rd_data_r[i]) begin
        if (take_hole(s_len, s_fnd, s_pl, policy_r, size_r)) begin
          s_fnd = 1'b1;
          s_pb  = s_st;
          s_pl  = s_len;
        end
        s_len = '0;
      end else begin
        if (s_len == '0) begin
          s_st = s_byte;
        end
        s_len = s_len + CW'(1);
      end
    end
  end

  // The hole still open at the end of memory.
  assign e_take = take_hole(run_len_r, found_r, pick_len_r, policy_r, size_r);

  // Bytes of the current word that fall inside the range being marked.
  always_comb begin
    m_mask = '0;
    m_new  = '0;
    m_byte = '0;
    for (int j = 0; j < 8; j++) begin
      m_byte    = XW'({mark_cur_r[AW-1:3], 3'(j)});
      m_mask[j] = (m_byte >= mark_cur_r) && (m_byte < mark_end_r);
      m_new     = m_new + 4'(m_mask[j] & ~rd_data_r[j]);
    end
    m_next = XW'({mark_cur_r[AW-1:3], 3'b000}) + XW'(8);
  end

  // Sequencer: next state, datapath updates and RAM controls.
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    proc_idx_nxt  = cnt_r[WA-1:0];
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    found_nxt     = found_r;
    pick_base_nxt = pick_base_r;
    pick_len_nxt  = pick_len_r;
    mark_cur_nxt  = mark_cur_r;
    mark_end_nxt  = mark_end_r;
    free_nxt      = free_r;
    status_nxt    = status_r;
    grant_nxt     = grant_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = cnt_r[WA-1:0];
    mem_waddr     = cnt_r[WA-1:0];
    mem_wdata     = '0;

    case (state_r)
      // Zero sweep after reset and for the clear operation.
      bhfa_pkg::S_INIT, bhfa_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + (WA+1)'(1);
        if (cnt_r[WA-1:0] == WA'(DEPTH - 1)) begin
          free_nxt  = CW'(MEM_BYTES);
          state_nxt = (state_r == bhfa_pkg::S_INIT) ? bhfa_pkg::S_IDLE
                                                    : bhfa_pkg::S_RESP;
        end
      end

      bhfa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          size_nxt   = in_tdata[24:12];
          status_nxt = bhfa_pkg::STATUS_OK;
          grant_nxt  = '0;
          cnt_nxt    = '0;
          case (in_tuser)
            bhfa_pkg::OP_ALLOC: begin
              if (in_tdata[24:12] == 13'd0) begin
                status_nxt = bhfa_pkg::STATUS_NOFIT;
                state_nxt  = bhfa_pkg::S_RESP;
              end else if (XW'(in_tdata[24:12]) > XW'(MEM_BYTES)) begin
                status_nxt = bhfa_pkg::STATUS_RANGE;
                state_nxt  = bhfa_pkg::S_RESP;
              end else begin
                run_len_nxt = '0;
                found_nxt   = 1'b0;
                state_nxt   = bhfa_pkg::S_SCAN;
              end
            end
            bhfa_pkg::OP_MARK: begin
              mark_cur_nxt = XW'(in_tdata[11:0]);
              mark_end_nxt = XW'(in_tdata[11:0]) + XW'(in_tdata[24:12]);
              if (XW'(in_tdata[11:0]) + XW'(in_tdata[24:12]) > XW'(MEM_BYTES)) begin
                status_nxt = bhfa_pkg::STATUS_RANGE;
                state_nxt  = bhfa_pkg::S_RESP;
              end else if (in_tdata[24:12] == 13'd0) begin
                state_nxt = bhfa_pkg::S_RESP;
              end else begin
                state_nxt = bhfa_pkg::S_MARK_RD;
              end
            end
            bhfa_pkg::OP_CLEAR: begin
              state_nxt = bhfa_pkg::S_CLEAR;
            end
            default: begin
              state_nxt = bhfa_pkg::S_RESP;
            end
          endcase
        end
      end

      // Stream map words through the read port, one per cycle.
      bhfa_pkg::S_SCAN: begin
        if (cnt_r < (WA+1)'(DEPTH)) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + (WA+1)'(1);
        end
        if (rd_vld_r) begin
          run_len_nxt   = s_len;
          run_start_nxt = s_st;
          found_nxt     = s_fnd;
          pick_base_nxt = s_pb;
          pick_len_nxt  = s_pl;
          if (proc_idx_r == WA'(DEPTH - 1)) begin
            state_nxt = bhfa_pkg::S_SCAN_END;
          end
        end
      end

      // Close the last hole and start marking the chosen one, or report no fit.
      bhfa_pkg::S_SCAN_END: begin
        if (e_take || found_r) begin
          grant_nxt    = e_take ? run_start_r : pick_base_r;
          mark_cur_nxt = XW'(e_take ? run_start_r : pick_base_r);
          mark_end_nxt = XW'(e_take ? run_start_r : pick_base_r) + XW'(size_r);
          state_nxt    = bhfa_pkg::S_MARK_RD;
        end else begin
          status_nxt = bhfa_pkg::STATUS_NOFIT;
          state_nxt  = bhfa_pkg::S_RESP;
        end
      end

      bhfa_pkg::S_MARK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = mark_cur_r[AW-1:3];
        state_nxt = bhfa_pkg::S_MARK_WR;
      end

      // Read-modify-write of one word; count the bytes that were free.
      bhfa_pkg::S_MARK_WR: begin
        mem_we       = 1'b1;
        mem_waddr    = mark_cur_r[AW-1:3];
        mem_wdata    = rd_data_r | m_mask;
        free_nxt     = free_r - CW'(m_new);
        mark_cur_nxt = m_next;
        state_nxt    = (m_next >= mark_end_r) ? bhfa_pkg::S_RESP : bhfa_pkg::S_MARK_RD;
      end

      bhfa_pkg::S_RESP: begin
        if (out_tready) begin
          state_nxt = bhfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bhfa_pkg::S_IDLE;
      end
    endcase
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bhfa_pkg::S_INIT;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      free_r   <= CW'(MEM_BYTES);
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      free_r   <= free_nxt;
      found_r  <= found_nxt;
    end
    size_r      <= size_nxt;
    proc_idx_r  <= proc_idx_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    pick_base_r <= pick_base_nxt;
    pick_len_r  <= pick_len_nxt;
    mark_cur_r  <= mark_cur_nxt;
    mark_end_r  <= mark_end_nxt;
    status_r    <= status_nxt;
    grant_r     <= grant_nxt;
  end

  // Handshakes and result payload.
  assign in_tready  = (state_r == bhfa_pkg::S_IDLE);
  assign out_tvalid = (state_r == bhfa_pkg::S_RESP);
  assign out_tdata  = {4'd0,
                       (XW'(size_r) <= XW'(free_r)),
                       13'(free_r),
                       12'(grant_r),
                       status_r};

endmodule

// File: sv/bhfa_checker.sv
// ----------------------------------------------------------------------------
// bhfa_checker
// Port-level checks on the allocator's streams, bound to the allocator unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bhfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // The block never takes input while a result is still waiting.
  `CHK_ASSERT(a_busy_excl, clk, rst_n, !(in_tready && out_tvalid))

  // An accepted input makes the block busy in the next cycle.
  `CHK_ASSERT(a_busy_after_in, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)

  // A stalled result holds its payload.
  `CHK_ASSERT(a_out_hold, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))

  // A granted base is only reported with an ok status.
  `CHK_ASSERT(a_grant_ok, clk, rst_n,
    (out_tvalid && out_tdata[1:0] != bhfa_pkg::STATUS_OK) |-> (out_tdata[13:2] == 12'd0))

  // No result is shown while reset is held.
  `CHK_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid)

endmodule

bind bitmap_hole_fit_allocator_unit bhfa_checker u_bhfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
